/* hw/rtl/string_to_integer_custom_base_macros.svh */
`ifndef STRING_TO_INTEGER_CUSTOM_BASE_MACROS_SVH
`define STRING_TO_INTEGER_CUSTOM_BASE_MACROS_SVH

// same-cycle check: ante implies cons on this edge
`define STIBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle check: ante implies cons on the following edge
`define STIBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/stibc_pkg.sv */
package stibc_pkg;

   localparam int MAX_BASE      = 16;
   localparam int SYM_BITS      = 8;
   localparam int ALPHA_BITS    = 64;
   localparam int BASE_LEN_BITS = 5;
   localparam int DIGIT_BITS    = $clog2(MAX_BASE);
   localparam int VALUE_BITS    = 32;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 64;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHABET_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHABET_HIGH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_LEN      = 2'd2;

   // character codes
   localparam logic [SYM_BITS-1:0] CHAR_SPACE  = 8'd32;
   localparam logic [SYM_BITS-1:0] WS_FIRST    = 8'd9;
   localparam logic [SYM_BITS-1:0] WS_LAST     = 8'd13;
   localparam logic [SYM_BITS-1:0] CHAR_PLUS   = 8'h2B;
   localparam logic [SYM_BITS-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [SYM_BITS-1:0] PRINT_FIRST = 8'd33;
   localparam logic [SYM_BITS-1:0] PRINT_LAST  = 8'd126;

   typedef struct packed {
      logic [SYM_BITS-1:0] symbol;
      logic                last_symbol;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         base_ok;
   } rsp_payload_type;

   // one classified word, as it travels through the queue
   typedef struct packed {
      logic                     last;
      logic                     base_ok;
      logic                     is_space;
      logic                     is_plus;
      logic                     is_minus;
      logic                     is_digit;
      logic [DIGIT_BITS-1:0]    digit;
      logic [BASE_LEN_BITS-1:0] radix;
   } class_type;

   typedef struct packed {
      logic      valid;
      class_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      class_type entry;
   } head_type;

endpackage

/* hw/rtl/stibc_front.sv */
module stibc_front import stibc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   input  logic                      queue_full,
   output push_type                  push
);

   logic [ALPHA_BITS-1:0]    alphabet_low_ff, alphabet_low_in;
   logic [ALPHA_BITS-1:0]    alphabet_high_ff, alphabet_high_in;
   logic [BASE_LEN_BITS-1:0] base_len_ff, base_len_in;

   logic [2*ALPHA_BITS-1:0]  alphabet;
   logic [SYM_BITS-1:0]      sym [MAX_BASE];
   logic [BASE_LEN_BITS-1:0] used_len;
   logic                     hit;
   logic [DIGIT_BITS-1:0]    digit;
   logic                     base_ok;
   logic [SYM_BITS-1:0]      c;

   always_comb begin
      alphabet_low_in  = alphabet_low_ff;
      alphabet_high_in = alphabet_high_ff;
      base_len_in      = base_len_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ALPHABET_LOW:  alphabet_low_in  = csr_write_data;
            CSR_ALPHABET_HIGH: alphabet_high_in = csr_write_data;
            CSR_BASE_LEN:      base_len_in      = csr_write_data[BASE_LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_low_ff  <= '0;
         alphabet_high_ff <= '0;
         base_len_ff      <= '0;
      end else begin
         alphabet_low_ff  <= alphabet_low_in;
         alphabet_high_ff <= alphabet_high_in;
         base_len_ff      <= base_len_in;
      end
   end

   assign alphabet = {alphabet_high_ff, alphabet_low_ff};
   assign c        = req_payload.symbol;
   assign used_len = (base_len_ff > BASE_LEN_BITS'(MAX_BASE)) ?
                     BASE_LEN_BITS'(MAX_BASE) : base_len_ff;

   always_comb begin
      for (int k = 0; k < MAX_BASE; k++) begin
         sym[k] = alphabet[k*SYM_BITS +: SYM_BITS];
      end
   end

   // parallel match, lowest index wins
   always_comb begin
      hit   = 1'b0;
      digit = '0;
      for (int k = MAX_BASE - 1; k >= 0; k--) begin
         if (BASE_LEN_BITS'(k) < used_len && sym[k] == c) begin
            hit   = 1'b1;
            digit = DIGIT_BITS'(k);
         end
      end
   end

   // alphabet check: length 2 to 16, printable, no signs, all distinct
   always_comb begin
      base_ok = (base_len_ff >= BASE_LEN_BITS'(2)) &&
                (base_len_ff <= BASE_LEN_BITS'(MAX_BASE));
      for (int i = 0; i < MAX_BASE; i++) begin
         if (BASE_LEN_BITS'(i) < base_len_ff) begin
            if (sym[i] < PRINT_FIRST || sym[i] > PRINT_LAST ||
                sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
               base_ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
               if (BASE_LEN_BITS'(j) < base_len_ff && sym[j] == sym[i]) begin
                  base_ok = 1'b0;
               end
            end
         end
      end
   end

   assign req_ready = !queue_full;

   always_comb begin
      push.valid          = req_valid && req_ready;
      push.entry.last     = req_payload.last_symbol;
      push.entry.base_ok  = base_ok;
      push.entry.is_space = (c inside {[WS_FIRST:WS_LAST], CHAR_SPACE});
      push.entry.is_plus  = (c == CHAR_PLUS);
      push.entry.is_minus = (c == CHAR_MINUS);
      push.entry.is_digit = hit;
      push.entry.digit    = digit;
      push.entry.radix    = used_len;
   end

endmodule

/* hw/rtl/stibc_queue.sv */
`include "string_to_integer_custom_base_macros.svh"

module stibc_queue import stibc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   class_type           entries [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push.valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries[wr_ptr_ff] <= push.entry;
      end
   end

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = entries[rd_ptr_ff];

   `STIBC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_BITS'(QUEUE_DEPTH), "queue overfilled")
   `STIBC_ASSERT_NOW(a_pop_nonempty, pop, count_ff != '0, "pop from empty queue")
   `STIBC_ASSERT_NEXT(a_push_count, push.valid && !pop, count_ff == $past(count_ff) + CNT_BITS'(1), "push lost")

endmodule

/* hw/rtl/stibc_back.sv */
`include "string_to_integer_custom_base_macros.svh"

module stibc_back import stibc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  head_type        head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_DIGITS,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic                  sign_ff, sign_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;

   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0] out_mag_ff, out_mag_in;
   logic                  out_neg_ff, out_neg_in;
   logic                  out_ok_ff, out_ok_in;

   logic [VALUE_BITS-1:0] prod;
   logic                  load;
   class_type             e;

   assign e    = head.entry;
   // a non-final word never needs the result register
   assign pop  = head.valid && (!e.last || !out_valid_ff || rsp_ready);
   assign load = pop && e.last;
   assign prod = acc_ff * VALUE_BITS'(e.radix);

   always_comb begin
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      sign_in      = sign_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_mag_in   = out_mag_ff;
      out_neg_in   = out_neg_ff;
      out_ok_in    = out_ok_ff;

      if (pop) begin
         case (phase_ff)
            PH_PREFIX: begin
               if (e.is_space) begin
                  if (sign_ff) phase_in = PH_ERROR;
               end else if (e.is_plus || e.is_minus) begin
                  if (e.is_minus) neg_in = !neg_ff;
                  sign_in = 1'b1;
               end else if (e.is_digit) begin
                  acc_in   = VALUE_BITS'(e.digit);
                  sign_in  = 1'b0;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_DIGITS: begin
               if (e.is_digit) acc_in = prod + VALUE_BITS'(e.digit);
               else            phase_in = PH_DONE;
            end
            default: ;
         endcase
      end

      if (load) begin
         out_valid_in = 1'b1;
         out_ok_in    = e.base_ok;
         out_neg_in   = neg_in;
         out_mag_in   = (e.base_ok && (phase_in == PH_DIGITS || phase_in == PH_DONE)) ?
                        acc_in : '0;
         phase_in     = PH_PREFIX;
         neg_in       = 1'b0;
         sign_in      = 1'b0;
         acc_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PREFIX;
         neg_ff       <= 1'b0;
         sign_ff      <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         sign_ff      <= sign_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
      out_mag_ff <= out_mag_in;
      out_neg_ff <= out_neg_in;
      out_ok_ff  <= out_ok_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_payload.value   = $signed(out_neg_ff ? (VALUE_BITS'(0) - out_mag_ff) : out_mag_ff);
   assign rsp_payload.base_ok = out_ok_ff;

   `STIBC_ASSERT_NEXT(a_last_gives_rsp, load, out_valid_ff, "final word gave no result")
   `STIBC_ASSERT_NEXT(a_last_clears, load, phase_ff == PH_PREFIX && acc_ff == '0 && !neg_ff && !sign_ff, "string state not cleared")
   `STIBC_ASSERT_NOW(a_bad_base_zero, rsp_valid && !rsp_payload.base_ok, rsp_payload.value == '0, "bad alphabet with nonzero value")

endmodule

/* hw/rtl/string_to_integer_custom_base.sv */
// A final word goes via the queue into the result register that drives rsp_valid.
// Throughput: one word per cycle while the queue has room (combinational multiply-add);
// the two-entry queue keeps the front taking words while the result register is stalled.
// Reset (synchronous, active high) zeroes the alphabet and radix registers, empties the
// queue, returns the parser to its prefix state and drops rsp_valid.
module string_to_integer_custom_base import stibc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_payload
);

   // front -> queue: classified word (digit match, whitespace, signs, alphabet check)
   push_type push;
   logic     queue_full;
   // queue -> back: oldest classified word
   head_type head;
   logic     pop;

   // front end: holds the alphabet registers, matches each symbol against the
   // alphabet slots in use (at most sixteen) in parallel and judges the alphabet itself
   stibc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .queue_full       (queue_full),
      .push             (push)
   );

   // short decoupling queue; ready to the requester depends only on its fill
   stibc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // back end: prefix/digit parser, accumulator and result register; only a
   // final word waits for a free result slot
   stibc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* verif/tb.sv */
module tb;
   import stibc_pkg::*;

   // no accepted word on either side for this many cycles ends the run
   localparam int STALL_LIMIT = 4000;
   // cycles to let the pipeline settle once every number has come back
   localparam int SETTLE_CYCLES = 8;
   // the receiver holds off once, after this many numbers
   localparam int HOLD_AFTER = 40;
   localparam int HOLD_CYCLES = 200;
   // at least this many words still waiting to be sent when the hold-off starts
   localparam int HOLD_BACKLOG = 40;
   // words per random phase
   localparam int PHASE_WORDS = 90;

   typedef enum logic [1:0] {
      SCAN_PREFIX,
      SCAN_DIGITS,
      SCAN_DONE,
      SCAN_ERROR
   } scan_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   // predictor's copy of the registers
   logic [ALPHA_BITS-1:0]    cfg_alpha_lo = '0;
   logic [ALPHA_BITS-1:0]    cfg_alpha_hi = '0;
   logic [BASE_LEN_BITS-1:0] cfg_radix = '0;

   // predictor's copy of the parser state
   scan_phase_type        scan_phase = SCAN_PREFIX;
   logic                  scan_neg = 1'b0;
   logic                  scan_sign_seen = 1'b0;
   logic [VALUE_BITS-1:0] scan_acc = '0;

   req_payload_type pending_chars[$];
   rsp_payload_type expected_numbers[$];

   int queued_words = 0;
   int sent_words = 0;
   int accepted_words = 0;
   int numbers_seen = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   logic req_fire;
   logic quiet;

   string_to_integer_custom_base i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // digits in use: the radix, capped at the alphabet size
   function automatic int radix_in_use();
      int n;
      n = cfg_radix;
      if (n > MAX_BASE) n = MAX_BASE;
      return n;
   endfunction

   function automatic logic [SYM_BITS-1:0] alpha_symbol(input int k);
      logic [ALPHA_BITS-1:0] w;
      w = (k < 8) ? cfg_alpha_lo : cfg_alpha_hi;
      return w[(k % 8) * 8 +: 8];
   endfunction

   // lowest alphabet index holding c, or -1
   function automatic int digit_value(input logic [SYM_BITS-1:0] c);
      int n;
      n = radix_in_use();
      for (int k = 0; k < n; k++) begin
         if (alpha_symbol(k) == c) return k;
      end
      return -1;
   endfunction

   function automatic logic alphabet_valid();
      int n;
      logic [SYM_BITS-1:0] c;
      n = cfg_radix;
      if (n < 2 || n > MAX_BASE) return 1'b0;
      for (int i = 0; i < n; i++) begin
         c = alpha_symbol(i);
         if (c < PRINT_FIRST || c > PRINT_LAST || c == CHAR_PLUS || c == CHAR_MINUS)
            return 1'b0;
         for (int j = i + 1; j < n; j++) begin
            if (alpha_symbol(j) == c) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic is_blank(input logic [SYM_BITS-1:0] c);
      return c == CHAR_SPACE || (c >= WS_FIRST && c <= WS_LAST);
   endfunction

   // advance the parser by one accepted word; a final word yields a number
   task automatic convert_word(input req_payload_type w);
      logic [SYM_BITS-1:0]   c;
      int                    d;
      logic [VALUE_BITS-1:0] v;
      rsp_payload_type       r;
      c = w.symbol;
      d = digit_value(c);
      case (scan_phase)
         SCAN_PREFIX: begin
            if (is_blank(c)) begin
               // a sign straight before whitespace spoils the string
               if (scan_sign_seen) scan_phase = SCAN_ERROR;
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               if (c == CHAR_MINUS) scan_neg = !scan_neg;
               scan_sign_seen = 1'b1;
            end else if (d >= 0) begin
               scan_acc = VALUE_BITS'(d);
               scan_sign_seen = 1'b0;
               scan_phase = SCAN_DIGITS;
            end else begin
               scan_phase = SCAN_ERROR;
            end
         end
         SCAN_DIGITS: begin
            // wraps mod 2^32
            if (d >= 0)
               scan_acc = scan_acc * VALUE_BITS'(radix_in_use()) + VALUE_BITS'(d);
            else
               scan_phase = SCAN_DONE;
         end
         default: ;
      endcase
      if (w.last_symbol) begin
         r.base_ok = alphabet_valid();
         v = '0;
         if (r.base_ok && (scan_phase == SCAN_DIGITS || scan_phase == SCAN_DONE))
            v = scan_neg ? -scan_acc : scan_acc;
         r.value = v;
         expected_numbers.push_back(r);
         scan_phase = SCAN_PREFIX;
         scan_neg = 1'b0;
         scan_sign_seen = 1'b0;
         scan_acc = '0;
      end
   endtask

   // ---------------------------------------------------------------
   // Driver: one word offered at a time, held until taken
   // ---------------------------------------------------------------
   assign quiet = (sent_words >= 500 && sent_words < 800);

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else begin
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            convert_word(req_payload);
            accepted_words++;
         end
         if (!req_valid || req_fire) begin
            if (pending_chars.size() > 0 && (quiet || $urandom_range(0, 99) >= 28)) begin
               req_valid <= 1'b1;
               req_payload <= pending_chars.pop_front();
               sent_words++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compare each number with the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            numbers_seen++;
            if (expected_numbers.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected number: value %0d base_ok %0b",
                           rsp_payload.value, rsp_payload.base_ok);
               mismatches++;
            end else begin
               rsp_payload_type want;
               want = expected_numbers.pop_front();
               if (rsp_payload.value !== want.value || rsp_payload.base_ok !== want.base_ok) begin
                  if (mismatches < 10)
                     $display("mismatch: value exp %0d got %0d, base_ok exp %0b got %0b",
                              want.value, rsp_payload.value, want.base_ok, rsp_payload.base_ok);
                  mismatches++;
               end
            end
         end
         // one long hold-off, with plenty still to send, so the queue fills and the input stalls
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && numbers_seen >= HOLD_AFTER &&
                      pending_chars.size() >= HOLD_BACKLOG) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(0, 99) >= 28);
         end
      end
   end

   // watchdog on progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL string_to_integer_custom_base");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic push_word(input logic [SYM_BITS-1:0] c, input logic last);
      req_payload_type w;
      w.symbol = c;
      w.last_symbol = last;
      pending_chars.push_back(w);
      queued_words++;
   endtask

   // whole text as one string, last flag on its final character
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_ALPHABET_LOW:  cfg_alpha_lo = data;
         CSR_ALPHABET_HIGH: cfg_alpha_hi = data;
         CSR_BASE_LEN:      cfg_radix = data[BASE_LEN_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic program_alphabet(input logic [127:0] syms, input logic [63:0] len_word);
      write_reg(CSR_ALPHABET_LOW, syms[63:0]);
      write_reg(CSR_ALPHABET_HIGH, syms[127:64]);
      write_reg(CSR_BASE_LEN, len_word);
   endtask

   // symbols from text, unused bytes left as junk
   function automatic logic [127:0] text_symbols(input string s);
      logic [127:0] r;
      r = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < s.len(); i++) r[i * 8 +: 8] = s[i];
      return r;
   endfunction

   // n distinct printable symbols, no signs
   function automatic logic [127:0] random_symbols(input int n);
      logic [127:0]        r;
      logic [SYM_BITS-1:0] c;
      bit                  taken[256];
      r = {$urandom, $urandom, $urandom, $urandom};
      for (int k = 0; k < n; k++) begin
         do begin
            c = SYM_BITS'($urandom_range(PRINT_FIRST, PRINT_LAST));
         end while (taken[c] || c == CHAR_PLUS || c == CHAR_MINUS);
         taken[c] = 1'b1;
         r[k * 8 +: 8] = c;
      end
      return r;
   endfunction

   function automatic logic [SYM_BITS-1:0] blank_char();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CHAR_SPACE : WS_FIRST + SYM_BITS'(k);
   endfunction

   function automatic logic [SYM_BITS-1:0] sign_char();
      return $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
   endfunction

   // mostly well-formed numbers, some broken prefixes, some noise
   task automatic random_string();
      logic [SYM_BITS-1:0] text[$];
      int kind, span;
      span = (radix_in_use() > 0) ? radix_in_use() - 1 : 15;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         repeat ($urandom_range(0, 2)) text.push_back(blank_char());
         repeat ($urandom_range(0, 2)) text.push_back(sign_char());
         // a few long runs to wrap the accumulator
         repeat ($urandom_range(1, (kind < 12) ? 12 : 5))
            text.push_back(alpha_symbol($urandom_range(0, span)));
         if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) text.push_back(SYM_BITS'($urandom_range(0, 255)));
      end else if (kind < 88) begin
         repeat ($urandom_range(0, 1)) text.push_back(blank_char());
         case (kind % 3)
            0: begin
               text.push_back(sign_char());
               text.push_back(blank_char());
               text.push_back(alpha_symbol($urandom_range(0, span)));
            end
            1: begin
               text.push_back(SYM_BITS'($urandom_range(0, 255)));
               text.push_back(alpha_symbol($urandom_range(0, span)));
            end
            default: begin
               // ends on a sign
               text.push_back(sign_char());
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) text.push_back(SYM_BITS'($urandom_range(0, 255)));
      end
      foreach (text[i]) push_word(text[i], i == text.size() - 1);
   endtask

   // every word taken, every number back, pipeline settled
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (!(accepted_words == queued_words && expected_numbers.size() == 0));
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int start;
      int n;
      int k;
      logic [127:0] syms;
      logic [SYM_BITS-1:0] bad;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // registers as they come out of reset: no alphabet at all
      push_text("7");
      wait_idle();

      // directed strings, decimal alphabet
      program_alphabet(text_symbols("0123456789"), 64'd10);
      for (int c = WS_FIRST; c <= WS_LAST; c++) push_word(SYM_BITS'(c), 1'b0);
      push_word(CHAR_SPACE, 1'b0);
      push_text("-9");
      push_text("+ 5");       // sign then whitespace
      push_text("x5");        // stray character before the digits
      push_text("-");         // ends on a sign
      push_text("12a3");      // tail after the digits ignored
      push_word(8'h00, 1'b1); // byte zero is an ordinary character
      push_word(8'hFF, 1'b1);
      push_text("--+3");      // two minus signs cancel

      for (int p = 0; p < 14; p++) begin
         wait_idle();
         case (p)
            0: program_alphabet(text_symbols("0123456789"), 64'd10);
            1: begin
               // junk above the radix field
               program_alphabet(text_symbols("0123456789ABCDEF"),
                                ({$urandom, $urandom} & ~64'h1F) | 64'd16);
            end
            2: program_alphabet(text_symbols("01"), 64'd2);
            3: begin
               n = $urandom_range(2, MAX_BASE);
               program_alphabet(random_symbols(n), 64'(n));
            end
            4: program_alphabet(text_symbols("!~"), 64'd2);
            5: program_alphabet(text_symbols("0123456789abcdef"), 64'd17);
            6: program_alphabet(text_symbols("0"), 64'd1);
            7: program_alphabet(text_symbols("abcde+"), 64'd6);  // bad final symbol
            8: program_alphabet(text_symbols("01230"), 64'd5);   // repeated symbol
            9: begin
               k = $urandom_range(0, 2);
               bad = (k == 0) ? CHAR_SPACE : (k == 1) ? PRINT_LAST + 8'd1 : 8'h00;
               syms = random_symbols(8);
               syms[$urandom_range(0, 7) * 8 +: 8] = bad;
               program_alphabet(syms, 64'd8);
            end
            10: program_alphabet(random_symbols(MAX_BASE), $urandom_range(0, 1) ? 64'd0 : 64'd31);
            11: program_alphabet(random_symbols(MAX_BASE), 64'(MAX_BASE));
            12: begin
               n = $urandom_range(2, MAX_BASE);
               program_alphabet(random_symbols(n), ({$urandom, $urandom} & ~64'h1F) | 64'(n));
            end
            default: begin
               program_alphabet({$urandom, $urandom, $urandom, $urandom},
                                {$urandom, $urandom});
            end
         endcase
         start = queued_words;
         while (queued_words - start < PHASE_WORDS) random_string();
      end

      wait_idle();
      if (mismatches == 0 && expected_numbers.size() == 0) begin
         $display("PASS string_to_integer_custom_base");
      end else begin
         $display("FAIL string_to_integer_custom_base");
      end
      $finish;
   end

endmodule

/* string_to_integer_custom_base.f */
+incdir+hw/rtl
hw/rtl/stibc_pkg.sv
hw/rtl/stibc_front.sv
hw/rtl/stibc_queue.sv
hw/rtl/stibc_back.sv
hw/rtl/string_to_integer_custom_base.sv
verif/tb.sv
